### hw/rtl/nsd_pkg.sv
// ---------------------------------------------------------------------------
// nsd_pkg
// Types and constants shared by the sentence deframer and its checker.
// ---------------------------------------------------------------------------
package nsd_pkg;

  // parse phase of the sentence framer
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DIGIT0  = 2'd2,
    PH_DIGIT1  = 2'd3
  } phase_t;

  // frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_BAD_HEX  = 2'd3;

  // sentence type codes
  localparam logic [2:0] TY_GSA     = 3'd0;
  localparam logic [2:0] TY_GGA     = 3'd1;
  localparam logic [2:0] TY_RMC     = 3'd2;
  localparam logic [2:0] TY_ZDA     = 3'd3;
  localparam logic [2:0] TY_UNKNOWN = 3'd4;

  // framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  localparam int HDR_LEN   = 5;
  localparam int NUM_TYPES = 4;

  // header table, one row per known type code
  localparam logic [7:0] HDR_TABLE [0:NUM_TYPES-1][0:HDR_LEN-1] = '{
    '{"G", "P", "G", "S", "A"},
    '{"G", "P", "G", "G", "A"},
    '{"G", "P", "R", "M", "C"},
    '{"G", "P", "Z", "D", "A"}
  };

  // result beat fields
  typedef struct packed {
    logic [7:0] received_checksum;
    logic [7:0] payload_length;
    logic [2:0] sentence_type;
    logic [1:0] frame_status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

  // hex digit decode: bit 4 is the valid flag, bits 3:0 the value (0 if invalid)
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

### hw/rtl/nmea_sentence_deframer_unit.sv
// ---------------------------------------------------------------------------
// nmea_sentence_deframer_unit
// Frames NMEA 0183 sentences from a character stream, checks the XOR
// checksum and classifies the header (GSA, GGA, RMC, ZDA).
// ---------------------------------------------------------------------------
//  channel   | dir | width | content
//  s_axis    | in  | 8     | tdata: rx_byte
//  m_axis    | out | 24    | tdata: frame_status, sentence_type,
//            |     |       |        payload_length, received_checksum
//
//  one character beat is taken per cycle while s_tready is high; the per-character update is one
//  compare, one xor and one counter step in a single register stage
//  a frame's result is registered from its last character into the output stage
//  a two-entry output stage (result register plus skid register) lets input
//  keep flowing while a result waits; s_tready drops only when both are full
//  rst clears the parse phase and the output valids, no clearing pass
// ---------------------------------------------------------------------------
module nmea_sentence_deframer_unit #(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  // bits 7:0 rx_byte
  input  logic [7:0]                  s_tdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // bits 1:0 frame_status, 4:2 sentence_type, 12:5 payload_length,
  // 20:13 received_checksum, 23:21 zero
  output logic [nsd_pkg::TDATA_W-1:0] m_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD);
  localparam logic [CW-1:0] HDR_CNT = CW'(nsd_pkg::HDR_LEN);

  // parse state
  nsd_pkg::phase_t  phase, phase_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [CW-1:0]    payload_count, payload_count_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic [3:0]       type_candidates, type_candidates_next;
  logic             digit_error, digit_error_next;

  // output stage
  nsd_pkg::result_t out_reg, skid_reg, res;
  logic             skid_valid;
  logic             res_valid;

  logic             in_fire;
  logic [4:0]       hex;
  logic [7:0]       csum;
  logic [2:0]       cur_type;
  logic [CW+7:0]    count_ext;
  logic [7:0]       count_lo;
  logic             at_max;

  assign in_fire   = s_tvalid && s_tready;
  assign hex       = nsd_pkg::hex_decode(s_tdata);
  assign csum      = {high_nibble, hex[3:0]};
  assign count_ext = {8'd0, payload_count};
  assign count_lo  = count_ext[7:0];
  assign at_max    = (payload_count == MAX_CNT);

  // type classified so far, lowest code wins
  always_comb begin
    cur_type = nsd_pkg::TY_UNKNOWN;
    if (payload_count >= HDR_CNT) begin
      if (type_candidates[0])      cur_type = nsd_pkg::TY_GSA;
      else if (type_candidates[1]) cur_type = nsd_pkg::TY_GGA;
      else if (type_candidates[2]) cur_type = nsd_pkg::TY_RMC;
      else if (type_candidates[3]) cur_type = nsd_pkg::TY_ZDA;
    end
  end

  // next parse phase
  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      case (phase)
        nsd_pkg::PH_HUNT: begin
          if (s_tdata == nsd_pkg::CH_DOLLAR) phase_next = nsd_pkg::PH_PAYLOAD;
        end
        nsd_pkg::PH_PAYLOAD: begin
          if (s_tdata == nsd_pkg::CH_STAR) phase_next = nsd_pkg::PH_DIGIT0;
          else if (at_max)                 phase_next = nsd_pkg::PH_HUNT;
        end
        nsd_pkg::PH_DIGIT0: phase_next = nsd_pkg::PH_DIGIT1;
        nsd_pkg::PH_DIGIT1: phase_next = nsd_pkg::PH_HUNT;
        default:            phase_next = nsd_pkg::PH_HUNT;
      endcase
    end
  end

  // datapath update and result
  always_comb begin
    running_xor_next     = running_xor;
    payload_count_next   = payload_count;
    high_nibble_next     = high_nibble;
    type_candidates_next = type_candidates;
    digit_error_next     = digit_error;
    res_valid            = 1'b0;
    res.frame_status      = nsd_pkg::ST_OK;
    res.sentence_type     = cur_type;
    res.payload_length    = count_lo;
    res.received_checksum = csum;
    if (in_fire) begin
      case (phase)
        nsd_pkg::PH_HUNT: begin
          if (s_tdata == nsd_pkg::CH_DOLLAR) begin
            running_xor_next     = 8'd0;
            payload_count_next   = '0;
            high_nibble_next     = 4'd0;
            type_candidates_next = 4'hF;
            digit_error_next     = 1'b0;
          end
        end
        nsd_pkg::PH_PAYLOAD: begin
          if (s_tdata != nsd_pkg::CH_STAR) begin
            if (at_max) begin
              res_valid             = 1'b1;
              res.frame_status      = nsd_pkg::ST_OVERFLOW;
              res.received_checksum = 8'd0;
            end else begin
              // narrow header candidates over the first five bytes
              if (payload_count < HDR_CNT) begin
                for (int i = 0; i < nsd_pkg::NUM_TYPES; i++) begin
                  if (nsd_pkg::HDR_TABLE[i][payload_count[2:0]] != s_tdata)
                    type_candidates_next[i] = 1'b0;
                end
              end
              running_xor_next   = running_xor ^ s_tdata;
              payload_count_next = payload_count + CW'(1);
            end
          end
        end
        nsd_pkg::PH_DIGIT0: begin
          high_nibble_next = hex[3:0];
          digit_error_next = ~hex[4];
        end
        nsd_pkg::PH_DIGIT1: begin
          res_valid = 1'b1;
          if (!hex[4] || digit_error)    res.frame_status = nsd_pkg::ST_BAD_HEX;
          else if (csum == running_xor)  res.frame_status = nsd_pkg::ST_OK;
          else                           res.frame_status = nsd_pkg::ST_MISMATCH;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= nsd_pkg::PH_HUNT;
      running_xor     <= 8'd0;
      payload_count   <= '0;
      high_nibble     <= 4'd0;
      type_candidates <= 4'hF;
      digit_error     <= 1'b0;
    end else begin
      phase           <= phase_next;
      running_xor     <= running_xor_next;
      payload_count   <= payload_count_next;
      high_nibble     <= high_nibble_next;
      type_candidates <= type_candidates_next;
      digit_error     <= digit_error_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // payload of the output stage
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) out_reg <= skid_reg;
    end else if (!m_tvalid || m_tready) begin
      out_reg <= res;
    end else if (res_valid) begin
      skid_reg <= res;
    end
  end

  assign s_tready = ~skid_valid;
  assign m_tdata  = {{(nsd_pkg::TDATA_W - nsd_pkg::RESULT_W){1'b0}}, out_reg};

endmodule

### hw/rtl/nsd_checker.sv
// ---------------------------------------------------------------------------
// nsd_port_checker
// Port-level checks on the sentence deframer, bound into every deframer instance.
// ---------------------------------------------------------------------------
module nsd_port_checker #(
  parameter int MAX_PAYLOAD = 128
) (
  input logic                        clk,
  input logic                        rst,
  input logic [7:0]                  s_tdata,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [nsd_pkg::TDATA_W-1:0] m_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready
);

  localparam int       CW      = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MAX_LO = 8'(MAX_PAYLOAD);

  nsd_pkg::result_t res;
  assign res = m_tdata[nsd_pkg::RESULT_W-1:0];

  // a stalled result holds its beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // input backpressure only while a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  // overflow carries a zero checksum and the length limit
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.frame_status == nsd_pkg::ST_OVERFLOW
      |-> res.received_checksum == 8'd0 && res.payload_length == MAX_LO)
    else $error("overflow result fields wrong");

  // type code range and zero padding
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.sentence_type <= nsd_pkg::TY_UNKNOWN &&
      m_tdata[nsd_pkg::TDATA_W-1:nsd_pkg::RESULT_W] == '0)
    else $error("bad type code or nonzero padding");

  // a known header needs five payload bytes (when the length cannot wrap)
  a_type: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.sentence_type != nsd_pkg::TY_UNKNOWN && CW <= 8
      |-> res.payload_length >= 8'(nsd_pkg::HDR_LEN))
    else $error("header classified on a short payload");

endmodule

bind nmea_sentence_deframer_unit nsd_port_checker #(
  .MAX_PAYLOAD(MAX_PAYLOAD)
) u_nsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tdata  (s_tdata),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
